// File: design/ehcd_pkg.sv
// ----------------------------------------------------------------------------
// ehcd_pkg
// Shared types and constants of the elevator hall call dispatcher.
// ----------------------------------------------------------------------------
`default_nettype none

package ehcd_pkg;

	localparam int NUM_ELEVATORS = 8;
	localparam int ID_W          = 3;
	localparam int FLOOR_W       = 6;
	localparam int DIR_W         = 2;
	localparam int TIME_W        = 32;
	localparam int COST_W        = 11;
	localparam int CFG_ADDR_W    = 2;
	localparam int CFG_DATA_W    = 32;

	// configuration register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_MIN_FLOOR = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_MAX_FLOOR = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_OUTDATED  = 2'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_DEAD      = 2'd3;

	// actions
	localparam logic ACT_UPDATE   = 1'b0;
	localparam logic ACT_DISPATCH = 1'b1;

	// travel directions
	localparam logic [DIR_W-1:0] DIR_NONE = 2'd0;
	localparam logic [DIR_W-1:0] DIR_UP   = 2'd1;
	localparam logic [DIR_W-1:0] DIR_DOWN = 2'd2;

	// settings that every cell sees, with the span penalties worked out once
	typedef struct packed {
		logic [FLOOR_W-1:0] min_floor;
		logic [FLOOR_W-1:0] max_floor;
		logic [TIME_W-1:0]  outdated;
		logic [TIME_W-1:0]  dead;
		logic [COST_W-1:0]  span_x10;
		logic [COST_W-1:0]  span_p1;
		logic [COST_W-1:0]  span_p1_x2;
	} cfg_t;

	// a dispatch walking down the row of cells
	typedef struct packed {
		logic               vld;
		logic [FLOOR_W-1:0] call_floor;
		logic               down_call;
		logic [TIME_W-1:0]  now;
		logic               found;
		logic [ID_W-1:0]    best_id;
		logic [COST_W-1:0]  best_cost;
	} tok_t;

	// record write from an update transaction
	typedef struct packed {
		logic [FLOOR_W-1:0] floor;
		logic [DIR_W-1:0]   dir;
		logic               stopped;
		logic [TIME_W-1:0]  stamp;
	} rec_t;

endpackage

`default_nettype wire

// File: design/ehcd_cell.sv
// ----------------------------------------------------------------------------
// ehcd_cell
// Holds one elevator record and scores a passing dispatch against it.
// ----------------------------------------------------------------------------
`default_nettype none

module ehcd_cell import ehcd_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic [ID_W-1:0] cell_id,
	input  wire cfg_t            cfg,
	input  wire logic            wr_en,
	input  wire rec_t            wr_rec,
	input  wire tok_t            tok_in,
	output tok_t                 tok_out
);

	logic              valid_q;
	rec_t              rec_q;
	tok_t              tok_q;

	logic [TIME_W-1:0]  age;
	logic [FLOOR_W-1:0] floor_gap;
	logic               live;
	logic               busy_dir;
	logic [COST_W-1:0]  cost;
	logic               take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rec_q   <= '0;
		end else if (wr_en) begin
			valid_q <= 1'b1;
			rec_q   <= wr_rec;
		end
	end

	always_comb begin
		age  = tok_in.now - rec_q.stamp;
		floor_gap = (rec_q.floor > tok_in.call_floor) ? (rec_q.floor - tok_in.call_floor)
		                                              : (tok_in.call_floor - rec_q.floor);
		live = valid_q && (age <= cfg.dead);
		busy_dir = ((rec_q.dir == DIR_UP) &&
		            ((!tok_in.down_call && (tok_in.call_floor > rec_q.floor)) ||
		             (tok_in.call_floor == cfg.max_floor))) ||
		           ((rec_q.dir == DIR_DOWN) &&
		            ((tok_in.down_call && (tok_in.call_floor < rec_q.floor)) ||
		             (tok_in.call_floor == cfg.min_floor)));
		cost = {{(COST_W-FLOOR_W){1'b0}}, floor_gap};
		if (age > cfg.outdated) cost = cost + cfg.span_x10;
		if (rec_q.stopped)      cost = cost + cfg.span_x10;
		priority if (busy_dir)
			cost = cost + cfg.span_p1;
		else if (rec_q.dir != DIR_NONE)
			cost = cost + cfg.span_p1_x2;
		else
			cost = cost;
		// strict compare keeps the lowest id on a tie
		take = live && (!tok_in.found || (cost < tok_in.best_cost));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q.vld        <= tok_in.vld;
			tok_q.call_floor <= tok_in.call_floor;
			tok_q.down_call  <= tok_in.down_call;
			tok_q.now        <= tok_in.now;
			tok_q.found      <= tok_in.found || take;
			tok_q.best_id    <= take ? cell_id : tok_in.best_id;
			tok_q.best_cost  <= take ? cost : tok_in.best_cost;
		end
	end

	assign tok_out = tok_q;

endmodule

`default_nettype wire

// File: design/elevator_hall_call_dispatcher.sv
// ----------------------------------------------------------------------------
// elevator_hall_call_dispatcher
// Keeps one record per elevator and picks the cheapest one for a hall call.
// ----------------------------------------------------------------------------
// An update transaction (action 0) writes its record at the accepting edge and
// gives no result; busy stays low, so the next transaction may follow at once.
// A dispatch transaction (action 1) walks the row of elevator cells, one cell
// per cycle, with a register in each cell; busy is high from the accepting edge
// until the dispatch leaves the last cell, and the result is shown with done high
// in the last cycle of busy, for exactly one cycle; the receiver must take it then.
// The next transaction can be accepted once busy has fallen. The walk through
// the cell row sets how long a dispatch takes. Configuration writes take effect
// at once and belong in idle time.
`default_nettype none

module elevator_hall_call_dispatcher import ehcd_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration
	input  wire logic                  cfg_we,
	input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	// command
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic                  action,
	input  wire logic [ID_W-1:0]       elev_id,
	input  wire logic [FLOOR_W-1:0]    floor,
	input  wire logic                  call_dir,
	input  wire logic [DIR_W-1:0]      moving_dir,
	input  wire logic                  is_stopped,
	input  wire logic [TIME_W-1:0]     time_ms,
	// result
	output logic                       done,
	output logic [ID_W-1:0]            chosen_id,
	output logic                       found,
	output logic [COST_W-1:0]          best_cost
);

	logic [FLOOR_W-1:0] min_floor_q;
	logic [FLOOR_W-1:0] max_floor_q;
	logic [TIME_W-1:0]  outdated_q;
	logic [TIME_W-1:0]  dead_q;

	logic [FLOOR_W-1:0] span;
	cfg_t               cfg;
	logic               accept;
	rec_t               wr_rec;
	tok_t               chain [0:NUM_ELEVATORS];
	logic [NUM_ELEVATORS-1:0] in_flight;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_floor_q <= FLOOR_W'(0);
			max_floor_q <= FLOOR_W'(3);
			outdated_q  <= TIME_W'(1200);
			dead_q      <= TIME_W'(3000);
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_MIN_FLOOR: min_floor_q <= cfg_wdata[FLOOR_W-1:0];
				REG_MAX_FLOOR: max_floor_q <= cfg_wdata[FLOOR_W-1:0];
				REG_OUTDATED:  outdated_q  <= cfg_wdata[TIME_W-1:0];
				REG_DEAD:      dead_q      <= cfg_wdata[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	// inverted bounds give a zero span
	assign span = (max_floor_q >= min_floor_q) ? (max_floor_q - min_floor_q) : '0;

	always_comb begin
		cfg.min_floor  = min_floor_q;
		cfg.max_floor  = max_floor_q;
		cfg.outdated   = outdated_q;
		cfg.dead       = dead_q;
		cfg.span_x10   = COST_W'({{(COST_W-FLOOR_W){1'b0}}, span} * COST_W'(10));
		cfg.span_p1    = {{(COST_W-FLOOR_W){1'b0}}, span} + COST_W'(1);
		cfg.span_p1_x2 = {cfg.span_p1[COST_W-2:0], 1'b0};
	end

	assign accept = start && !busy;

	assign wr_rec.floor   = floor;
	assign wr_rec.dir     = moving_dir;
	assign wr_rec.stopped = is_stopped;
	assign wr_rec.stamp   = time_ms;

	always_comb begin
		chain[0].vld        = accept && (action == ACT_DISPATCH);
		chain[0].call_floor = floor;
		chain[0].down_call  = call_dir;
		chain[0].now        = time_ms;
		chain[0].found      = 1'b0;
		chain[0].best_id    = '0;
		chain[0].best_cost  = '0;
	end

	for (genvar g = 0; g < NUM_ELEVATORS; g++) begin : g_cell
		ehcd_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cell_id (ID_W'(g)),
			.cfg     (cfg),
			.wr_en   (accept && (action == ACT_UPDATE) && (elev_id == ID_W'(g))),
			.wr_rec  (wr_rec),
			.tok_in  (chain[g]),
			.tok_out (chain[g+1])
		);
		assign in_flight[g] = chain[g+1].vld;
	end

	assign busy      = |in_flight;
	assign done      = chain[NUM_ELEVATORS].vld;
	assign chosen_id = chain[NUM_ELEVATORS].best_id;
	assign found     = chain[NUM_ELEVATORS].found;
	assign best_cost = chain[NUM_ELEVATORS].best_cost;

endmodule

`default_nettype wire
